/* rtl/bda_pkg.sv */
package bda_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int SUM_W       = 38;
    localparam int MERGE_W     = 7;
    localparam int FILL_W      = 6;
    localparam int POS_W       = 12;
    localparam int OUT_W       = 16;
    localparam int REM_W       = 6;
    localparam int CNT_W       = 6;
    localparam int SCALE_W     = 14;
    localparam int PROD_W      = SUM_W + SCALE_W;
    localparam int SCALE_SHIFT = 26;
    localparam int SCALED_W    = PROD_W - SCALE_SHIFT;

    localparam logic [SCALE_W-1:0] SCALE_MUL         = 14'd13422;
    localparam logic [MERGE_W-1:0] SHORT_MERGE_LIMIT = 7'd4;
    localparam logic [CNT_W-1:0]   DIV_LAST_STEP     = 6'(SUM_W - 1);
    localparam logic [SCALED_W-1:0] POS_LIMIT        = 26'd32767;
    localparam logic [SCALED_W-1:0] NEG_LIMIT        = 26'd32768;
    localparam logic [OUT_W-1:0]   OUT_MAX           = 16'h7fff;
    localparam logic [OUT_W-1:0]   OUT_MIN           = 16'h8000;

    // one closed group, handed from the front to the back
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [MERGE_W-1:0]      merge;
        logic [POS_W-1:0]        pos;
        logic                    last;
    } group_req_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_DONE = 4'b1000
    } back_state_t;

endpackage

/* rtl/bda_front.sv */
module bda_front #(
    parameter int BUFFER_SAMPLES       = 4096,
    parameter int SHORT_BUFFER_SAMPLES = 1024,
    parameter int MAX_MERGE            = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [bda_pkg::MERGE_W-1:0]           cfg_write_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [bda_pkg::SAMPLE_W-1:0]   raw_sample,
    output logic                                  push_valid,
    input  logic                                  push_ready,
    output bda_pkg::group_req_t                   push_data
);

    logic [bda_pkg::MERGE_W-1:0]       avg_len_reg;
    logic signed [bda_pkg::SUM_W-1:0]  group_sum_reg, group_sum_next;
    logic [bda_pkg::FILL_W-1:0]        group_fill_reg, group_fill_next;
    logic [bda_pkg::POS_W-1:0]         out_position_reg, out_position_next;

    logic [bda_pkg::MERGE_W-1:0]       merge_eff;
    logic [bda_pkg::POS_W:0]           buf_size;
    logic signed [bda_pkg::SUM_W-1:0]  sum_new;
    logic                              close_group;
    logic                              is_last;
    logic                              accept;

    // clamp the merge count into its legal range
    always_comb
    begin
        if (avg_len_reg == '0)
            merge_eff = bda_pkg::MERGE_W'(1);
        else if (avg_len_reg > bda_pkg::MERGE_W'(MAX_MERGE))
            merge_eff = bda_pkg::MERGE_W'(MAX_MERGE);
        else
            merge_eff = avg_len_reg;
    end

    // group close and buffer position
    always_comb
    begin
        buf_size    = (merge_eff < bda_pkg::SHORT_MERGE_LIMIT)
                      ? (bda_pkg::POS_W+1)'(SHORT_BUFFER_SAMPLES)
                      : (bda_pkg::POS_W+1)'(BUFFER_SAMPLES);
        sum_new     = group_sum_reg
                      + {{(bda_pkg::SUM_W-bda_pkg::SAMPLE_W){raw_sample[bda_pkg::SAMPLE_W-1]}},
                         raw_sample};
        close_group = !(({1'b0, group_fill_reg} + bda_pkg::MERGE_W'(1)) < merge_eff);
        is_last     = ({1'b0, out_position_reg} + (bda_pkg::POS_W+1)'(1)) >= buf_size;
    end

    assign in_ready   = push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = in_valid && close_group;

    assign push_data.sum   = sum_new;
    assign push_data.merge = merge_eff;
    assign push_data.pos   = out_position_reg;
    assign push_data.last  = is_last;

    // accumulator update per accepted request
    always_comb
    begin
        group_sum_next    = group_sum_reg;
        group_fill_next   = group_fill_reg;
        out_position_next = out_position_reg;
        if (accept)
        begin
            if (close_group)
            begin
                group_sum_next    = '0;
                group_fill_next   = '0;
                out_position_next = is_last ? '0 : out_position_reg + bda_pkg::POS_W'(1);
            end
            else
            begin
                group_sum_next  = sum_new;
                group_fill_next = group_fill_reg + bda_pkg::FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_len_reg      <= bda_pkg::MERGE_W'(4);
            group_sum_reg    <= '0;
            group_fill_reg   <= '0;
            out_position_reg <= '0;
        end
        else
        begin
            if (cfg_write_en)
                avg_len_reg <= cfg_write_data;
            group_sum_reg    <= group_sum_next;
            group_fill_reg   <= group_fill_next;
            out_position_reg <= out_position_next;
        end
    end

endmodule

/* rtl/bda_queue.sv */
module bda_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  bda_pkg::group_req_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output bda_pkg::group_req_t pop_data
);

    bda_pkg::group_req_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage slots
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/bda_back.sv */
module bda_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pop_valid,
    output logic                               pop_ready,
    input  bda_pkg::group_req_t                pop_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [bda_pkg::OUT_W-1:0]   sample_out,
    output logic [bda_pkg::POS_W-1:0]          sample_index,
    output logic                               buffer_last
);

    bda_pkg::back_state_t state_reg, state_next;

    logic [bda_pkg::SUM_W-1:0]    quot_reg;
    logic [bda_pkg::REM_W-1:0]    rem_reg;
    logic [bda_pkg::MERGE_W-1:0]  div_reg;
    logic [bda_pkg::CNT_W-1:0]    cnt_reg;
    logic                         neg_reg;
    logic [bda_pkg::POS_W-1:0]    pos_reg;
    logic                         last_reg;
    logic [bda_pkg::PROD_W-1:0]   prod_reg;

    logic                         out_valid_reg;
    logic [bda_pkg::OUT_W-1:0]    out_data_reg;
    logic [bda_pkg::POS_W-1:0]    out_pos_reg;
    logic                         out_last_reg;

    logic [bda_pkg::MERGE_W-1:0]  rem_shift;
    logic                         rem_ge;
    logic [bda_pkg::SUM_W-1:0]    sum_mag;
    logic [bda_pkg::SCALED_W-1:0] scaled;
    logic [bda_pkg::OUT_W-1:0]    result;
    logic                         out_free;
    logic                         load_out;
    logic                         take;

    assign pop_ready = (state_reg == bda_pkg::ST_IDLE);
    assign take      = pop_valid && pop_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign load_out  = (state_reg == bda_pkg::ST_DONE) && out_free;

    // magnitude of the group sum
    assign sum_mag = pop_data.sum[bda_pkg::SUM_W-1]
                     ? (~pop_data.sum + bda_pkg::SUM_W'(1))
                     : pop_data.sum;

    // one restoring division step
    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[bda_pkg::SUM_W-1]};
        rem_ge    = (rem_shift >= div_reg);
    end

    // scale and saturate
    always_comb
    begin
        scaled = prod_reg[bda_pkg::PROD_W-1:bda_pkg::SCALE_SHIFT];
        if (neg_reg)
            result = (scaled > bda_pkg::NEG_LIMIT) ? bda_pkg::OUT_MIN
                                                   : (~scaled[bda_pkg::OUT_W-1:0]
                                                      + bda_pkg::OUT_W'(1));
        else
            result = (scaled > bda_pkg::POS_LIMIT) ? bda_pkg::OUT_MAX
                                                   : scaled[bda_pkg::OUT_W-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bda_pkg::ST_IDLE:
                if (take)
                    state_next = bda_pkg::ST_DIV;
            bda_pkg::ST_DIV:
                if (cnt_reg == bda_pkg::DIV_LAST_STEP)
                    state_next = bda_pkg::ST_MUL;
            bda_pkg::ST_MUL:
                state_next = bda_pkg::ST_DONE;
            bda_pkg::ST_DONE:
                if (out_free)
                    state_next = bda_pkg::ST_IDLE;
            default:
                state_next = bda_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bda_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
                cnt_reg <= '0;
            else if (state_reg == bda_pkg::ST_DIV)
                cnt_reg <= cnt_reg + bda_pkg::CNT_W'(1);
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            quot_reg <= sum_mag;
            rem_reg  <= '0;
            div_reg  <= pop_data.merge;
            neg_reg  <= pop_data.sum[bda_pkg::SUM_W-1];
            pos_reg  <= pop_data.pos;
            last_reg <= pop_data.last;
        end
        else if (state_reg == bda_pkg::ST_DIV)
        begin
            quot_reg <= {quot_reg[bda_pkg::SUM_W-2:0], rem_ge};
            rem_reg  <= rem_ge ? bda_pkg::REM_W'(rem_shift - div_reg)
                               : bda_pkg::REM_W'(rem_shift);
        end
        if (state_reg == bda_pkg::ST_MUL)
            prod_reg <= bda_pkg::PROD_W'(quot_reg) * bda_pkg::PROD_W'(bda_pkg::SCALE_MUL);
        if (load_out)
        begin
            out_data_reg <= result;
            out_pos_reg  <= pos_reg;
            out_last_reg <= last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_out   = out_data_reg;
    assign sample_index = out_pos_reg;
    assign buffer_last  = out_last_reg;

    // checks
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bda_pkg::ST_DIV) |-> (cnt_reg <= bda_pkg::DIV_LAST_STEP))
        else $error("division step count overran");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bda_pkg::ST_DIV) |-> (div_reg != '0))
        else $error("zero divisor in division");

    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bda_pkg::ST_MUL) |=> (state_reg == bda_pkg::ST_DONE))
        else $error("multiply not followed by result stage");

    a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bda_pkg::ST_DONE && out_valid_reg && !out_ready)
        |=> (state_reg == bda_pkg::ST_DONE))
        else $error("result overwrote a pending output");

endmodule

/* rtl/boxcar_decimating_averager.sv */
// channel   direction  handshake                 payload
// cfg       in         cfg_write_en              cfg_write_data[6:0] (average length)
// in        in         in_valid / in_ready       raw_sample[31:0] signed
// out       out        out_valid / out_ready     sample_out[15:0] signed, sample_index[11:0],
//                                                buffer_last
//
// the front takes one sample request per cycle while the group queue has room
// each closed group passes through the back in steps: load, 38 division steps, multiply, result
// the bit-serial divider in the back sets the output rate
// reset clears the accumulator, buffer position, queue and output; the average length resets to 4
// a two-entry group queue and the output register let front and back stall on their own
module boxcar_decimating_averager #(
    parameter int BUFFER_SAMPLES       = 4096,
    parameter int SHORT_BUFFER_SAMPLES = 1024,
    parameter int MAX_MERGE            = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [bda_pkg::MERGE_W-1:0]           cfg_write_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [bda_pkg::SAMPLE_W-1:0]   raw_sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [bda_pkg::OUT_W-1:0]      sample_out,
    output logic [bda_pkg::POS_W-1:0]             sample_index,
    output logic                                  buffer_last
);

    logic                push_valid, push_ready;
    bda_pkg::group_req_t push_data;
    logic                pop_valid, pop_ready;
    bda_pkg::group_req_t pop_data;

    // accumulate and close groups
    bda_front #(
        .BUFFER_SAMPLES       (BUFFER_SAMPLES),
        .SHORT_BUFFER_SAMPLES (SHORT_BUFFER_SAMPLES),
        .MAX_MERGE            (MAX_MERGE)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_sample     (raw_sample),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    // closed group queue
    bda_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // divide, scale, saturate
    bda_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_out   (sample_out),
        .sample_index (sample_index),
        .buffer_last  (buffer_last)
    );

endmodule

/* tb/sv/tb_boxcar_decimating_averager.sv */
`timescale 1ns / 100ps

module tb_boxcar_decimating_averager;

    localparam int CLK_PERIOD           = 4;
    localparam int BUFFER_SAMPLES       = 4096;
    localparam int SHORT_BUFFER_SAMPLES = 1024;
    localparam int MAX_MERGE            = 64;
    localparam int RANDOM_ITEMS         = 300;
    localparam int DRAIN_CYCLES         = 48;
    localparam int WATCHDOG_LIMIT       = 4000;
    localparam int REPORT_LIMIT         = 10;

    // one averaged output sample as it leaves the block
    typedef struct packed {
        logic signed [bda_pkg::OUT_W-1:0] value;
        logic [bda_pkg::POS_W-1:0]        index;
        logic                             last;
    } avg_result_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } row_kind_t;

    // directed row: an average length write or a run of identical samples
    typedef struct packed {
        row_kind_t                           kind;
        logic signed [bda_pkg::SAMPLE_W-1:0] data;
        logic [7:0]                          reps;
        logic                                typed;
        avg_result_t                         res;
    } stim_row_t;

    localparam int DIRECTED_LEN = 23;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        // reset average length of four, small values scale to zero
        '{ROW_SAMPLE, 32'sd100, 8'd1, 1'b0, '0},
        '{ROW_SAMPLE, 32'sd200, 8'd1, 1'b0, '0},
        '{ROW_SAMPLE, 32'sd300, 8'd1, 1'b0, '0},
        '{ROW_SAMPLE, 32'sd400, 8'd1, 1'b1, '{16'sd0, 12'd0, 1'b0}},
        // single-sample groups at the input extremes, at zero and at minus one
        '{ROW_WRITE, 32'sd1, 8'd1, 1'b0, '0},
        '{ROW_SAMPLE, 32'sh7fffffff, 8'd1, 1'b1, '{16'sh7fff, 12'd1, 1'b0}},
        '{ROW_SAMPLE, 32'sh80000000, 8'd1, 1'b1, '{16'sh8000, 12'd2, 1'b0}},
        '{ROW_SAMPLE, 32'sd0, 8'd1, 1'b1, '{16'sd0, 12'd3, 1'b0}},
        '{ROW_SAMPLE, -32'sd1, 8'd1, 1'b1, '{16'sd0, 12'd4, 1'b0}},
        // right at the saturation threshold on both sides
        '{ROW_SAMPLE, 32'sd163840000, 8'd1, 1'b0, '0},
        '{ROW_SAMPLE, -32'sd163840000, 8'd1, 1'b0, '0},
        // average length of zero acts as one
        '{ROW_WRITE, 32'sd0, 8'd1, 1'b0, '0},
        '{ROW_SAMPLE, 32'sd5000000, 8'd1, 1'b0, '0},
        // lowering the average length mid-group closes the group on the next sample
        '{ROW_WRITE, 32'sd8, 8'd1, 1'b0, '0},
        '{ROW_SAMPLE, 32'sd1000, 8'd5, 1'b0, '0},
        '{ROW_WRITE, 32'sd3, 8'd1, 1'b0, '0},
        '{ROW_SAMPLE, 32'sd1000, 8'd1, 1'b0, '0},
        // average length above the maximum is clamped
        '{ROW_WRITE, 32'sd127, 8'd1, 1'b0, '0},
        '{ROW_SAMPLE, 32'sh7fffffff, 8'd1, 1'b0, '0},
        '{ROW_SAMPLE, 32'sh80000000, 8'd1, 1'b0, '0},
        '{ROW_WRITE, 32'sd65, 8'd1, 1'b0, '0},
        '{ROW_SAMPLE, 32'sd12345, 8'd1, 1'b0, '0},
        '{ROW_WRITE, 32'sd64, 8'd1, 1'b0, '0}
    };

    localparam logic [bda_pkg::MERGE_W-1:0] MERGE_EDGES [10] = '{
        7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd63, 7'd64, 7'd65, 7'd127
    };

    logic                                clk            = 1'b0;
    logic                                rst_n          = 1'b0;
    logic                                cfg_write_en   = 1'b0;
    logic [bda_pkg::MERGE_W-1:0]         cfg_write_data = '0;
    logic                                in_valid       = 1'b0;
    logic                                in_ready;
    logic signed [bda_pkg::SAMPLE_W-1:0] raw_sample     = '0;
    logic                                out_valid;
    logic                                out_ready      = 1'b0;
    logic signed [bda_pkg::OUT_W-1:0]    sample_out;
    logic [bda_pkg::POS_W-1:0]           sample_index;
    logic                                buffer_last;

    // predictor state
    logic [bda_pkg::MERGE_W-1:0]         merge_setting = 7'd4;
    logic signed [bda_pkg::SUM_W-1:0]    group_acc     = '0;
    logic [bda_pkg::FILL_W-1:0]          group_fill    = '0;
    logic [bda_pkg::POS_W-1:0]           position      = '0;

    avg_result_t pending_results [$];
    avg_result_t want;
    int          mismatch_count = 0;
    int          stall_cycles   = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;

    boxcar_decimating_averager #(
        .BUFFER_SAMPLES       (BUFFER_SAMPLES),
        .SHORT_BUFFER_SAMPLES (SHORT_BUFFER_SAMPLES),
        .MAX_MERGE            (MAX_MERGE)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_sample     (raw_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_out     (sample_out),
        .sample_index   (sample_index),
        .buffer_last    (buffer_last)
    );

    always #(CLK_PERIOD / 2.0) clk = ~clk;

    function automatic int clamp_merge(input logic [bda_pkg::MERGE_W-1:0] value);
        if (value == '0)
            return 1;
        if (int'(value) > MAX_MERGE)
            return MAX_MERGE;
        return int'(value);
    endfunction

    // full-range values with extremes and values near saturation mixed in; styles 0 and 1 give only one extreme
    function automatic logic signed [bda_pkg::SAMPLE_W-1:0] next_sample(input int style);
        if (style == 0)
            return 32'sh7fffffff;
        if (style == 1)
            return 32'sh80000000;
        case ($urandom_range(0, 7))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2, 3:    return $signed($urandom_range(0, 400000000)) - 200000000;
            default: return $urandom;
        endcase
    endfunction

    // accumulate one sample, close the group when full
    task automatic average_sample(input logic signed [bda_pkg::SAMPLE_W-1:0] s,
                                  output bit closed, output avg_result_t res);
        int                    eff;
        int                    size;
        longint                quotient;
        longint unsigned       magnitude;
        longint unsigned       scaled;
        eff = clamp_merge(merge_setting);
        size = (eff < int'(bda_pkg::SHORT_MERGE_LIMIT)) ? SHORT_BUFFER_SAMPLES : BUFFER_SAMPLES;
        closed = 1'b0;
        res = '0;
        group_acc = group_acc + s;
        if (int'(group_fill) + 1 < eff)
        begin
            group_fill = group_fill + 1'b1;
        end
        else
        begin
            quotient = longint'(group_acc) / eff;
            magnitude = (quotient < 0) ? -quotient : quotient;
            scaled = (magnitude * bda_pkg::SCALE_MUL) >> bda_pkg::SCALE_SHIFT;
            if (quotient < 0)
            begin
                if (scaled > 32768)
                    scaled = 32768;
                res.value = bda_pkg::OUT_W'(-scaled);
            end
            else
            begin
                if (scaled > 32767)
                    scaled = 32767;
                res.value = bda_pkg::OUT_W'(scaled);
            end
            res.index = position;
            res.last = (int'(position) + 1 >= size);
            position = res.last ? '0 : position + 1'b1;
            group_acc = '0;
            group_fill = '0;
            closed = 1'b1;
        end
    endtask

    // one sample request, with a random gap in front of it
    task automatic send_sample(input logic signed [bda_pkg::SAMPLE_W-1:0] value,
                               input bit typed, input avg_result_t typed_res);
        bit          closed;
        avg_result_t res;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_sample <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        average_sample(value, closed, res);
        if (closed)
            pending_results.push_back(typed ? typed_res : res);
    endtask

    // average length write once the block has gone quiet
    task automatic write_merge(input logic [bda_pkg::MERGE_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        merge_setting = value;
    endtask

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endtask

    // receiver stalls
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // compare each result request with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                note_failure($sformatf("unexpected result: out=%0d idx=%0d last=%0b",
                                       sample_out, sample_index, buffer_last));
            end
            else
            begin
                want = pending_results.pop_front();
                if (sample_out !== want.value || sample_index !== want.index ||
                    buffer_last !== want.last)
                    note_failure($sformatf(
                        "mismatch: expected out=%0d idx=%0d last=%0b, got out=%0d idx=%0d last=%0b",
                        want.value, want.index, want.last,
                        sample_out, sample_index, buffer_last));
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no request accepted for %0d cycles", stall_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int                          rand_items;
        int                          eff;
        int                          count;
        int                          style;
        logic [bda_pkg::MERGE_W-1:0] pick;

        // reset
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles often less than the receiver
        send_idle_pct = 18;
        recv_idle_pct = 51;

        // directed table
        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].kind == ROW_WRITE)
                write_merge(DIRECTED_ROWS[i].data[bda_pkg::MERGE_W-1:0]);
            else
                repeat (DIRECTED_ROWS[i].reps)
                    send_sample(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed,
                                DIRECTED_ROWS[i].res);
        end

        // random segments, each at its own average length, often ending mid-group
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            if (rand_items >= RANDOM_ITEMS / 2)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 18;
            end
            case ($urandom_range(0, 3))
                0:       pick = MERGE_EDGES[$urandom_range(0, 9)];
                1:       pick = bda_pkg::MERGE_W'($urandom_range(0, 127));
                default: pick = bda_pkg::MERGE_W'($urandom_range(1, 16));
            endcase
            write_merge(pick);
            eff = clamp_merge(pick);
            count = eff * $urandom_range(1, (eff > 16) ? 2 : 10) + $urandom_range(0, eff - 1);
            style = $urandom_range(0, 7);
            repeat (count) send_sample(next_sample(style), 1'b0, '0);
            rand_items += count;
        end

        // no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // single-sample groups up to the wrap of the short buffer
        write_merge(7'd1);
        while (position == '0)
            send_sample(next_sample(2), 1'b0, '0);
        while (position != '0)
            send_sample(next_sample(2), 1'b0, '0);

        // drain
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
